[hdl/lpd_pkg.sv]
// Package for the linked pool deque: widths, index types, operation and
// status codes, sequencer states and the memory request structs.
// No dependencies.
package lpd_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int IDX_W      = $clog2(POOL_DEPTH + 1);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int VALUE_W    = 32;

    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_idx NULL_IDX = t_idx'(POOL_DEPTH);

    typedef enum logic [1:0] {
        KIND_PUSH_LEFT  = 2'd0,
        KIND_PUSH_RIGHT = 2'd1,
        KIND_POP_LEFT   = 2'd2,
        KIND_POP_RIGHT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_PUSH_TAIL,
        S_WALK,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  re;
        t_addr raddr;
        logic  we;
        t_addr waddr;
        t_idx  wdata;
    } t_link_req;

    typedef struct packed {
        logic   re;
        t_addr  raddr;
        logic   we;
        t_addr  waddr;
        t_value wdata;
    } t_value_req;

    typedef struct packed {
        t_value  value;
        t_status status;
    } t_result;

    function automatic logic is_null(input t_idx idx);
        return idx >= NULL_IDX;
    endfunction

    function automatic t_addr to_addr(input t_idx idx);
        return idx[ADDR_W-1:0];
    endfunction

endpackage

[hdl/lpd_link_mem.sv]
// Next-index memory of the node pool: one write and one registered read
// per cycle. Per-entry valid bits stand in for the reset chain i -> i+1.
// Depends on lpd_pkg.
module lpd_link_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpd_pkg::t_link_req i_req,
    output lpd_pkg::t_idx     o_rd_data
);
    import lpd_pkg::*;

    t_idx                  r_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] r_valid;
    t_idx                  r_q;
    logic                  r_q_valid;
    t_addr                 r_q_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q       <= r_mem[i_req.raddr];
            r_q_valid <= r_valid[i_req.raddr];
            r_q_addr  <= i_req.raddr;
        end
    end

    // an entry never written still holds its reset link to the next slot
    assign o_rd_data = r_q_valid ? r_q : (t_idx'(r_q_addr) + t_idx'(1));

endmodule

[hdl/lpd_value_mem.sv]
// Node value memory: one write and one registered read per cycle; the read
// data holds until the next read. Depends on lpd_pkg.
module lpd_value_mem (
    input  logic                i_clk,
    input  lpd_pkg::t_value_req i_req,
    output lpd_pkg::t_value     o_rd_data
);
    import lpd_pkg::*;

    t_value r_mem [POOL_DEPTH];
    t_value r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_q;

endmodule

[hdl/lpd_seq.sv]
// Operation sequencer of the deque: holds the free head and both ends,
// drives the link and value memories and walks the chain on pop right.
// Depends on lpd_pkg.
module lpd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lpd_pkg::t_kind      i_kind,
    input  lpd_pkg::t_value     i_value,
    output logic                o_ready,
    output lpd_pkg::t_link_req  o_link_req,
    input  lpd_pkg::t_idx       i_link_q,
    output lpd_pkg::t_value_req o_value_req,
    input  lpd_pkg::t_value     i_value_q,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output lpd_pkg::t_result    o_result
);
    import lpd_pkg::*;

    t_state  r_state, n_state;
    t_idx    r_free, n_free;
    t_idx    r_left, n_left;
    t_idx    r_right, n_right;
    t_idx    r_node, n_node;
    t_idx    r_walk, n_walk;
    t_cnt    r_steps, n_steps;
    t_kind   r_kind, n_kind;
    t_result r_res, n_res;

    logic deque_empty;
    logic walk_more;

    assign deque_empty = is_null(r_left) || is_null(r_right);
    assign walk_more   = (r_steps < t_cnt'(POOL_DEPTH)) && !is_null(i_link_q)
                         && (i_link_q != r_node);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= '0;
            r_left  <= NULL_IDX;
            r_right <= NULL_IDX;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_walk  <= n_walk;
        r_steps <= n_steps;
        r_kind  <= n_kind;
        r_res   <= n_res;
    end

    // next state and pointer updates
    always_comb begin
        n_state = r_state;
        n_free  = r_free;
        n_left  = r_left;
        n_right = r_right;
        n_node  = r_node;
        n_walk  = r_walk;
        n_steps = r_steps;
        n_kind  = r_kind;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_kind;
                    n_res  = '{value: '0, status: STATUS_DONE};
                    unique case (i_kind)
                        KIND_PUSH_LEFT, KIND_PUSH_RIGHT: begin
                            if (is_null(r_free)) begin
                                n_res.status = STATUS_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_node  = r_free;
                                n_state = S_LINK;
                            end
                        end
                        KIND_POP_LEFT: begin
                            if (deque_empty) begin
                                n_res.status = STATUS_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_node  = r_left;
                                n_state = S_LINK;
                            end
                        end
                        KIND_POP_RIGHT: begin
                            if (deque_empty) begin
                                n_res.status = STATUS_EMPTY;
                                n_state      = S_DONE;
                            end else if (r_left == r_right) begin
                                n_node  = r_right;
                                n_left  = NULL_IDX;
                                n_right = NULL_IDX;
                                n_state = S_FREE;
                            end else begin
                                n_node  = r_right;
                                n_walk  = r_left;
                                n_steps = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LINK: begin
                if (r_kind == KIND_POP_LEFT) begin
                    n_res.value = i_value_q;
                    n_free      = r_node;
                    if (is_null(i_link_q)) begin
                        n_left  = NULL_IDX;
                        n_right = NULL_IDX;
                    end else begin
                        n_left = i_link_q;
                    end
                    n_state = S_DONE;
                end else begin
                    n_free = i_link_q;
                    if (deque_empty) begin
                        n_left  = r_node;
                        n_right = r_node;
                        n_state = S_DONE;
                    end else if (r_kind == KIND_PUSH_LEFT) begin
                        n_left  = r_node;
                        n_state = S_DONE;
                    end else begin
                        n_right = r_node;
                        n_state = S_PUSH_TAIL;
                    end
                end
            end
            S_PUSH_TAIL: begin
                n_state = S_DONE;
            end
            S_WALK: begin
                if (walk_more) begin
                    n_walk  = i_link_q;
                    n_steps = r_steps + t_cnt'(1);
                end else begin
                    n_right = r_walk;
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                n_res.value = i_value_q;
                n_free      = r_node;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory requests and handshake
    always_comb begin
        o_link_req  = '0;
        o_value_req = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    unique case (i_kind)
                        KIND_PUSH_LEFT, KIND_PUSH_RIGHT: begin
                            if (!is_null(r_free)) begin
                                o_link_req.re     = 1'b1;
                                o_link_req.raddr  = to_addr(r_free);
                                o_value_req.we    = 1'b1;
                                o_value_req.waddr = to_addr(r_free);
                                o_value_req.wdata = i_value;
                            end
                        end
                        KIND_POP_LEFT: begin
                            if (!deque_empty) begin
                                o_link_req.re     = 1'b1;
                                o_link_req.raddr  = to_addr(r_left);
                                o_value_req.re    = 1'b1;
                                o_value_req.raddr = to_addr(r_left);
                            end
                        end
                        KIND_POP_RIGHT: begin
                            if (!deque_empty) begin
                                o_value_req.re    = 1'b1;
                                o_value_req.raddr = to_addr(r_right);
                                o_link_req.re     = (r_left != r_right);
                                o_link_req.raddr  = to_addr(r_left);
                            end
                        end
                        default: o_link_req = '0;
                    endcase
                end
            end
            S_LINK: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = to_addr(r_node);
                if (r_kind == KIND_POP_LEFT) begin
                    o_link_req.wdata = r_free;
                end else if (deque_empty || r_kind == KIND_PUSH_RIGHT) begin
                    if (!deque_empty) begin
                        // hook the new node behind the old right end first
                        o_link_req.waddr = to_addr(r_right);
                        o_link_req.wdata = r_node;
                    end else begin
                        o_link_req.wdata = NULL_IDX;
                    end
                end else begin
                    o_link_req.wdata = r_left;
                end
            end
            S_PUSH_TAIL: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = to_addr(r_node);
                o_link_req.wdata = NULL_IDX;
            end
            S_WALK: begin
                if (walk_more) begin
                    o_link_req.re    = 1'b1;
                    o_link_req.raddr = to_addr(i_link_q);
                end else begin
                    o_link_req.we    = 1'b1;
                    o_link_req.waddr = to_addr(r_walk);
                    o_link_req.wdata = NULL_IDX;
                end
            end
            S_FREE: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = to_addr(r_node);
                o_link_req.wdata = r_free;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: o_ready = 1'b0;
        endcase
    end

    assign o_result = r_res;

endmodule

[hdl/linked_pool_deque.sv]
// Top level of the linked pool deque: stream ports, sequencer, the two pool
// memories and the output word register.
// Depends on lpd_pkg, lpd_link_mem, lpd_value_mem and lpd_seq.
//
//  channel    | direction | tdata              | tuser
//  -----------+-----------+--------------------+------------------------------
//  s_axis     | in        | push_value [31:0]  | kind [1:0]
//  m_axis     | out       | pop_value  [31:0]  | status [1:0]
//
// One word at a time. Push and pop left pass through the link state to the
// result register; push right into a non-empty deque adds a tail-write state.
// A push into a full pool or a pop from an empty deque goes straight to done.
// Pop right of a single entry goes through the free state. Otherwise it walks
// the link memory one read a cycle from the left end, passing at most
// POOL_DEPTH nodes, then frees the old right node.
// Synchronous active-low reset; the link chain comes from per-entry valid
// bits, so no clearing pass is needed and words are taken right after reset.
// A full output register stalls the sequencer in its done state; the input
// is taken again once the result has moved into the output register.
module linked_pool_deque (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic signed [31:0]    i_s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]            i_s_axis_tuser,   // [1:0] kind
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic signed [31:0]    o_m_axis_tdata,   // [31:0] pop_value
    output logic [1:0]            o_m_axis_tuser    // [1:0] status
);
    import lpd_pkg::*;

    logic       start;
    logic       seq_ready;
    logic       res_valid;
    logic       res_ready;
    t_result    result;
    t_link_req  link_req;
    t_idx       link_q;
    t_value_req value_req;
    t_value     value_q;

    logic       r_out_valid;
    t_value     r_out_value;
    t_status    r_out_status;

    // take a word only when the sequencer sits idle
    assign o_s_axis_tready = seq_ready;
    assign start           = i_s_axis_tvalid && seq_ready;

    // the output register frees up in the same cycle its word is taken
    assign res_ready = !r_out_valid || i_m_axis_tready;

    lpd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (t_kind'(i_s_axis_tuser)),
        .i_value     (i_s_axis_tdata),
        .o_ready     (seq_ready),
        .o_link_req  (link_req),
        .i_link_q    (link_q),
        .o_value_req (value_req),
        .i_value_q   (value_q),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (result)
    );

    lpd_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (link_req),
        .o_rd_data (link_q)
    );

    lpd_value_mem u_value_mem (
        .i_clk     (i_clk),
        .i_req     (value_req),
        .o_rd_data (value_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_value  <= result.value;
            r_out_status <= result.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;

    // an accepted word closes the input until its result is handed off
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_s_axis_tready)
        else $error("input accepted while an operation is in flight");

    // a handed-off result lands in the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |=> r_out_valid)
        else $error("result lost on hand-off");

    // failed operations carry a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STATUS_DONE) |-> (r_out_value == '0))
        else $error("failed operation with nonzero value");

    // hold the input closed while a result is on offer
    a_busy_while_offering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !seq_ready)
        else $error("result offered while idle");

endmodule

[dv/tb_linked_pool_deque.sv]
// Testbench for linked_pool_deque: drives push and pop words on the input stream,
// predicts every result from a model of the node pool, and checks the output stream.
// Depends on lpd_pkg and the linked_pool_deque RTL.
module tb_linked_pool_deque;
    import lpd_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_LIMIT = 40;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   s_valid = 1'b0;
    t_value s_value = '0;
    t_kind  s_kind = KIND_PUSH_LEFT;
    logic   m_ready = 1'b0;

    logic   o_s_axis_tready;
    logic   o_m_axis_tvalid;
    t_value o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;

    linked_pool_deque i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_value),          // [31:0] push_value
        .i_s_axis_tuser  (s_kind),           // [1:0] kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] pop_value
        .o_m_axis_tuser  (o_m_axis_tuser)    // [1:0] status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Deque model: node pool, links, free list head and both ends.
    t_value pool_value [POOL_DEPTH];
    t_idx   pool_link  [POOL_DEPTH];
    t_idx   free_head_idx;
    t_idx   left_idx;
    t_idx   right_idx;
    int     deque_fill;

    t_result pending_results [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      cycle_count = 0;
    int      burst_left = 0;

    // Chain every node onto the free list; both ends start null.
    task automatic clear_pool();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_value[i] = '0;
            pool_link[i]  = t_idx'(i + 1);
        end
        free_head_idx = '0;
        left_idx      = NULL_IDX;
        right_idx     = NULL_IDX;
        deque_fill    = 0;
    endtask

    // Apply one word to the model and return the result it must produce.
    function automatic t_result predict_deque(t_kind op, t_value val);
        t_result r;
        t_idx    node;
        t_idx    walk;
        int      steps;
        r.value  = '0;
        r.status = STATUS_DONE;
        if (op == KIND_PUSH_LEFT || op == KIND_PUSH_RIGHT) begin
            if (free_head_idx >= NULL_IDX) begin
                r.status = STATUS_FULL;
            end else begin
                node            = free_head_idx;
                free_head_idx   = pool_link[node];
                pool_value[node] = val;
                deque_fill++;
                if (left_idx >= NULL_IDX || right_idx >= NULL_IDX) begin
                    // first entry becomes both ends
                    pool_link[node] = NULL_IDX;
                    left_idx        = node;
                    right_idx       = node;
                end else if (op == KIND_PUSH_LEFT) begin
                    pool_link[node] = left_idx;
                    left_idx        = node;
                end else begin
                    pool_link[right_idx] = node;
                    pool_link[node]      = NULL_IDX;
                    right_idx            = node;
                end
            end
        end else if (left_idx >= NULL_IDX || right_idx >= NULL_IDX) begin
            r.status = STATUS_EMPTY;
        end else if (op == KIND_POP_LEFT) begin
            node            = left_idx;
            r.value         = pool_value[node];
            left_idx        = pool_link[node];
            pool_link[node] = free_head_idx;
            free_head_idx   = node;
            deque_fill--;
            if (left_idx >= NULL_IDX) begin
                left_idx  = NULL_IDX;
                right_idx = NULL_IDX;
            end
        end else begin
            node    = right_idx;
            r.value = pool_value[node];
            if (left_idx == right_idx) begin
                // single entry: empty the deque, no walk
                left_idx  = NULL_IDX;
                right_idx = NULL_IDX;
            end else begin
                // walk from the left end to the predecessor of the right node
                walk  = left_idx;
                steps = 0;
                while (steps < POOL_DEPTH && pool_link[walk] < NULL_IDX
                       && pool_link[walk] != node) begin
                    walk = pool_link[walk];
                    steps++;
                end
                pool_link[walk] = NULL_IDX;
                right_idx       = walk;
            end
            pool_link[node] = free_head_idx;
            free_head_idx   = node;
            deque_fill--;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // Send one word; bursts of random length are separated by random gaps.
    task automatic send_word(t_kind op, t_value val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_kind  <= op;
        s_value <= val;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_deque(op, val));
        items_sent++;
    endtask

    // Hold the input idle until every expected result has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return t_value'($urandom);
        endcase
    endfunction

    // Edge values, pops on an empty deque, single-entry pops and walks.
    task automatic test_directed();
        send_word(KIND_POP_LEFT,   32'h1111_1111);
        send_word(KIND_POP_RIGHT,  32'h2222_2222);
        send_word(KIND_PUSH_LEFT,  32'h7fff_ffff);
        send_word(KIND_POP_RIGHT,  '0);
        send_word(KIND_PUSH_RIGHT, 32'h8000_0000);
        send_word(KIND_POP_LEFT,   '0);
        send_word(KIND_POP_LEFT,   '1);
        send_word(KIND_PUSH_LEFT,  '0);
        send_word(KIND_PUSH_RIGHT, '1);
        send_word(KIND_PUSH_LEFT,  32'h0000_0001);
        send_word(KIND_PUSH_RIGHT, 32'h5555_5555);
        send_word(KIND_PUSH_LEFT,  32'haaaa_aaaa);
        send_word(KIND_POP_RIGHT,  '0);
        send_word(KIND_POP_RIGHT,  '0);
        send_word(KIND_POP_LEFT,   '0);
        send_word(KIND_POP_RIGHT,  '0);
        send_word(KIND_POP_RIGHT,  '0);
        send_word(KIND_POP_RIGHT,  '0);
        send_word(KIND_PUSH_RIGHT, 32'h1234_5678);
        send_word(KIND_POP_LEFT,   32'hffff_0000);
    endtask

    // Fill the pool, push twice into it while full, then drain from the right so
    // that pops walk long chains down to a single entry; pop right once more when empty.
    task automatic test_full_pool();
        while (deque_fill < POOL_DEPTH)
            send_word($urandom_range(0, 1) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT, pick_value());
        send_word(KIND_PUSH_LEFT,  pick_value());
        send_word(KIND_PUSH_RIGHT, pick_value());
        while (deque_fill > 0)
            send_word(KIND_POP_RIGHT, pick_value());
        send_word(KIND_POP_RIGHT, pick_value());
    endtask

    // Segments with a push bias drift the fill between empty and full.
    task automatic test_random_mix();
        int    push_pct;
        int    seg_len;
        t_kind op;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            seg_len = $urandom_range(20, 90);
            repeat (seg_len) begin
                if ($urandom_range(1, 100) <= push_pct)
                    op = $urandom_range(0, 1) ? KIND_PUSH_RIGHT : KIND_PUSH_LEFT;
                else
                    op = $urandom_range(0, 1) ? KIND_POP_RIGHT : KIND_POP_LEFT;
                send_word(op, pick_value());
            end
        end
    endtask

    // Receiver stalls: one of four ready modes, picked anew at random.
    int ready_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (hold_left > 0) begin
                    m_ready   <= 1'b0;
                    hold_left <= hold_left - 1;
                end else begin
                    m_ready   <= 1'b1;
                    hold_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 25) : 0;
                end
            end
        endcase
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %0d status %0d",
                                          o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want.value)
                    report_mismatch($sformatf("pop_value %0d, want %0d",
                                              o_m_axis_tdata, want.value));
                if (o_m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_m_axis_tuser, want.status));
            end
        end
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        clear_pool();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_full_pool();
        wait_drained();
        test_random_mix();
        wait_drained();

        // allow for a stray word after the last expected one
        repeat (POOL_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
